### hdl/usv_pkg.sv
`timescale 1ns / 1ps

package usv_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CP_W   = 21;
    localparam int STAT_W = 3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_TRUNC    = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADBYTE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVERLONG = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADCP    = 3'd4;

    localparam logic [CP_W-1:0] CP_MAX_1 = 21'h00007F;
    localparam logic [CP_W-1:0] CP_MAX_2 = 21'h0007FF;
    localparam logic [CP_W-1:0] CP_MAX_3 = 21'h00FFFF;
    localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_BAD
    } cls_kind_t;

    typedef struct packed {
        cls_kind_t  kind;
        logic [6:0] bits;
    } cls_beat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

### hdl/usv_front.sv
`timescale 1ns / 1ps

module usv_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  usv_pkg::queue_stat_t q_stat,
    output logic               push,
    output usv_pkg::cls_beat_t push_beat
);
    import usv_pkg::*;

    assign s_ready = !q_stat.full;
    assign push    = s_valid && !q_stat.full;

    always_comb begin
        push_beat.bits = s_data_byte[6:0];
        priority if (s_data_byte == 8'h00) begin
            push_beat.kind = CLS_ZERO;
        end else if (s_data_byte[7] == 1'b0) begin
            push_beat.kind = CLS_ASCII;
        end else if (s_data_byte[7:6] == 2'b10) begin
            push_beat.kind = CLS_CONT;
        end else if (s_data_byte[7:5] == 3'b110) begin
            push_beat.kind = CLS_LEAD2;
        end else if (s_data_byte[7:4] == 4'b1110) begin
            push_beat.kind = CLS_LEAD3;
        end else if (s_data_byte[7:3] == 5'b11110) begin
            push_beat.kind = CLS_LEAD4;
        end else begin
            push_beat.kind = CLS_BAD;
        end
    end

endmodule

### hdl/usv_queue.sv
`timescale 1ns / 1ps

module usv_queue #(
    parameter int DEPTH = usv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  usv_pkg::cls_beat_t   push_beat,
    input  logic                 pop,
    output usv_pkg::cls_beat_t   pop_beat,
    output usv_pkg::queue_stat_t q_stat
);
    import usv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_beat_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_beat     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

### hdl/usv_back.sv
`timescale 1ns / 1ps

module usv_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  usv_pkg::queue_stat_t          q_stat,
    input  usv_pkg::cls_beat_t            pop_beat,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [usv_pkg::CP_W-1:0]      m_code_point,
    output logic [usv_pkg::STAT_W-1:0]    m_status
);
    import usv_pkg::*;

    logic [1:0]        bytes_left_reg, bytes_left_next;
    logic [2:0]        seq_len_reg, seq_len_next;
    logic [CP_W-1:0]   partial_reg, partial_next;
    logic              m_valid_reg, m_valid_next;
    logic [CP_W-1:0]   cp_reg, cp_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic              emit;
    logic [CP_W-1:0]   fin_cp;
    logic [2:0]        fin_len;
    logic              fin;
    logic              overlong;
    logic              bad_cp;
    logic [CP_W-1:0]   shifted;

    assign pop = !q_stat.empty && (!m_valid_reg || m_ready);

    assign shifted  = {partial_reg[CP_W-7:0], pop_beat.bits[5:0]};
    assign overlong = ((fin_cp <= CP_MAX_1) && (fin_len > 3'd1)) ||
                      ((fin_cp <= CP_MAX_2) && (fin_len > 3'd2)) ||
                      ((fin_cp <= CP_MAX_3) && (fin_len > 3'd3));
    assign bad_cp   = (fin_cp > CP_MAX) || ((fin_cp >= SURR_LO) && (fin_cp <= SURR_HI));

    always_comb begin
        bytes_left_next = bytes_left_reg;
        seq_len_next    = seq_len_reg;
        partial_next    = partial_reg;
        emit            = 1'b0;
        fin             = 1'b0;
        fin_cp          = shifted;
        fin_len         = seq_len_reg;
        cp_next         = '0;
        status_next     = ST_TRUNC;

        if (bytes_left_reg == 2'd0) begin
            fin_cp  = {14'd0, pop_beat.bits};
            fin_len = 3'd1;
            unique case (pop_beat.kind)
                CLS_ZERO: begin
                    emit        = 1'b1;
                    status_next = ST_TRUNC;
                end
                CLS_ASCII: begin
                    fin = 1'b1;
                end
                CLS_LEAD2: begin
                    partial_next    = {16'd0, pop_beat.bits[4:0]};
                    seq_len_next    = 3'd2;
                    bytes_left_next = 2'd1;
                end
                CLS_LEAD3: begin
                    partial_next    = {17'd0, pop_beat.bits[3:0]};
                    seq_len_next    = 3'd3;
                    bytes_left_next = 2'd2;
                end
                CLS_LEAD4: begin
                    partial_next    = {18'd0, pop_beat.bits[2:0]};
                    seq_len_next    = 3'd4;
                    bytes_left_next = 2'd3;
                end
                default: begin
                    emit        = 1'b1;
                    status_next = ST_BADBYTE;
                end
            endcase
        end else if (pop_beat.kind != CLS_CONT) begin
            emit            = 1'b1;
            status_next     = ST_TRUNC;
            bytes_left_next = 2'd0;
            seq_len_next    = 3'd0;
            partial_next    = '0;
        end else begin
            bytes_left_next = bytes_left_reg - 2'd1;
            partial_next    = shifted;
            fin             = (bytes_left_reg == 2'd1);
        end

        if (fin) begin
            emit            = 1'b1;
            bytes_left_next = 2'd0;
            seq_len_next    = 3'd0;
            partial_next    = '0;
            priority if (overlong) begin
                status_next = ST_OVERLONG;
            end else if (bad_cp) begin
                status_next = ST_BADCP;
            end else begin
                status_next = ST_OK;
                cp_next     = fin_cp;
            end
        end

        if (!pop) begin
            bytes_left_next = bytes_left_reg;
            seq_len_next    = seq_len_reg;
            partial_next    = partial_reg;
        end

        m_valid_next = m_valid_reg && !m_ready;
        if (pop && emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 2'd0;
            seq_len_reg    <= 3'd0;
            partial_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            seq_len_reg    <= seq_len_next;
            partial_reg    <= partial_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            cp_reg     <= cp_next;
            status_reg <= status_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_code_point = cp_reg;
    assign m_status     = status_reg;

endmodule

### hdl/utf8_stream_validator.sv
`timescale 1ns / 1ps

// Byte-stream code point decoder and checker. One byte is taken per beat on
// s_; each sequence end or error gives one result beat on m_ (code_point is
// zero unless status is ok). Sustained rate is one byte per cycle while the
// result side keeps up. The last byte of a sequence enters the classify
// queue at the accepting edge, and the back part loads the output register
// when it pops that byte, which waits while a result is held unaccepted. The
// queue of QUEUE_DEPTH classified bytes lets the input keep flowing for that
// many beats while the result side stalls.
module utf8_stream_validator #(
    parameter int QUEUE_DEPTH = usv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_data_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [usv_pkg::CP_W-1:0]   m_code_point,
    output logic [usv_pkg::STAT_W-1:0] m_status
);
    import usv_pkg::*;

    queue_stat_t q_stat;
    cls_beat_t   push_beat;
    cls_beat_t   pop_beat;
    logic        push;
    logic        pop;

    usv_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_stat      (q_stat),
        .push        (push),
        .push_beat   (push_beat)
    );

    usv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_beat (push_beat),
        .pop       (pop),
        .pop_beat  (pop_beat),
        .q_stat    (q_stat)
    );

    usv_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .pop_beat     (pop_beat),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_status     (m_status)
    );

    a_err_zero_cp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_code_point == '0))
        else $error("error result carries nonzero code point");

    a_ok_scalar: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_OK)) |->
        ((m_code_point <= CP_MAX) && ((m_code_point < SURR_LO) || (m_code_point > SURR_HI))))
        else $error("ok result is not a valid scalar");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_BADCP))
        else $error("status code out of range");

    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty) && (!pop || !q_stat.empty))
        else $error("queue flags inconsistent");

endmodule
